// ===== hw/rtl/pdb_pkg.sv =====
// Package for the point distance and bearing block.
// Constants, the arctangent table and the pipeline flag type shared by all
// pdb_* modules. No dependencies.
package pdb_pkg;

   localparam int unsigned DIST_W   = 19;
   localparam int unsigned BEAR_W   = 15;
   localparam int unsigned RSP_W    = 40;
   localparam int unsigned MAG_W    = 17;
   localparam int unsigned SQ_W     = 2 * MAG_W;
   localparam int unsigned ROOT_W   = 40;
   localparam int unsigned ROOT_STEPS = 20;
   localparam int unsigned XY_FRAC  = 16;
   localparam int unsigned XY_GUARD = 20;
   localparam int unsigned Z_W      = 32;
   localparam int unsigned ATAN_LEN = 24;

   localparam logic [DIST_W-1:0] DIST_MAX     = 19'h7FFFF;
   localparam logic [BEAR_W:0]   BEARING_FULL = 16'd23040;
   localparam logic signed [Z_W-1:0] DEG180   = 32'sd754974720;
   localparam logic signed [Z_W-1:0] DEG360   = 32'sd1509949440;
   localparam logic [Z_W:0]      ROUND_HALF   = 33'd32768;

   // atan(2^-i) in 2^-22 degree
   localparam logic signed [Z_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
      32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
      32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
      32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
      32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
      32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
      32'sd229,       32'sd115,       32'sd57,       32'sd29
   };

   typedef struct packed {
      logic valid;
      logic zero;
      logic sat;
   } pdb_flags_type;

endpackage

// ===== hw/rtl/pdb_front.sv =====
// Front end: difference, magnitudes, squares, radicand and CORDIC prerotation.
// Four register stages. Depends on pdb_pkg.
module pdb_front #(
   parameter int unsigned COORD_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic signed [COORD_WIDTH-1:0]  from_x,
   input  logic signed [COORD_WIDTH-1:0]  from_y,
   input  logic signed [COORD_WIDTH-1:0]  to_x,
   input  logic signed [COORD_WIDTH-1:0]  to_y,
   output pdb_pkg::pdb_flags_type         out_flags,
   output logic signed [COORD_WIDTH+pdb_pkg::XY_GUARD-1:0] out_x,
   output logic signed [COORD_WIDTH+pdb_pkg::XY_GUARD-1:0] out_y,
   output logic signed [pdb_pkg::Z_W-1:0] out_z,
   output logic [pdb_pkg::ROOT_W-1:0]     out_rem
);
   import pdb_pkg::*;

   localparam int unsigned DW   = COORD_WIDTH + 1;
   localparam int unsigned XY_W = COORD_WIDTH + XY_GUARD;
   localparam int unsigned AW   = (DW > MAG_W + 1) ? DW : MAG_W + 1;

   // stage A
   pdb_flags_type          a_flags_ff, a_flags_in;
   logic signed [DW-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   // stage B
   pdb_flags_type          b_flags_ff, b_flags_in;
   logic signed [XY_W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic signed [Z_W-1:0]  bz_ff, bz_in;
   logic [MAG_W-1:0]       mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   // stage C
   pdb_flags_type          c_flags_ff, c_flags_in;
   logic signed [XY_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [Z_W-1:0]  cz_ff, cz_in;
   logic [SQ_W-1:0]        sq_a_ff, sq_a_in, sq_b_ff, sq_b_in;
   // stage D
   pdb_flags_type          d_flags_ff, d_flags_in;
   logic signed [XY_W-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic signed [Z_W-1:0]  ez_ff, ez_in;
   logic [ROOT_W-1:0]      n_ff, n_in;

   logic [AW-1:0]          abs_a, abs_b;
   logic signed [XY_W-1:0] x0, y0;

   always_comb begin
      a_flags_in       = '0;
      a_flags_in.valid = in_valid;
      dx_in = DW'(to_x) - DW'(from_x);
      dy_in = DW'(to_y) - DW'(from_y);

      abs_a = AW'(unsigned'(dx_ff[DW-1] ? -dx_ff : dx_ff));
      abs_b = AW'(unsigned'(dy_ff[DW-1] ? -dy_ff : dy_ff));
      b_flags_in.valid = a_flags_ff.valid;
      b_flags_in.zero  = (dx_ff == '0) && (dy_ff == '0);
      b_flags_in.sat   = (|abs_a[AW-1:MAG_W]) || (|abs_b[AW-1:MAG_W]);
      mag_a_in = abs_a[MAG_W-1:0];
      mag_b_in = abs_b[MAG_W-1:0];
      x0 = XY_W'(dy_ff) <<< XY_FRAC;
      y0 = XY_W'(dx_ff) <<< XY_FRAC;
      if (dy_ff[DW-1]) begin
         bx_in = -x0;
         by_in = -y0;
         bz_in = DEG180;
      end else begin
         bx_in = x0;
         by_in = y0;
         bz_in = '0;
      end

      c_flags_in = b_flags_ff;
      cx_in   = bx_ff;
      cy_in   = by_ff;
      cz_in   = bz_ff;
      sq_a_in = mag_a_ff * mag_a_ff;
      sq_b_in = mag_b_ff * mag_b_ff;

      d_flags_in = c_flags_ff;
      ex_in = cx_ff;
      ey_in = cy_ff;
      ez_in = cz_ff;
      n_in  = (ROOT_W'(sq_a_ff) + ROOT_W'(sq_b_ff)) << 4;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_flags_ff <= '0;
         b_flags_ff <= '0;
         c_flags_ff <= '0;
         d_flags_ff <= '0;
      end else if (adv) begin
         a_flags_ff <= a_flags_in;
         b_flags_ff <= b_flags_in;
         c_flags_ff <= c_flags_in;
         d_flags_ff <= d_flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         bx_ff    <= bx_in;
         by_ff    <= by_in;
         bz_ff    <= bz_in;
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         cz_ff    <= cz_in;
         sq_a_ff  <= sq_a_in;
         sq_b_ff  <= sq_b_in;
         ex_ff    <= ex_in;
         ey_ff    <= ey_in;
         ez_ff    <= ez_in;
         n_ff     <= n_in;
      end
   end

   assign out_flags = d_flags_ff;
   assign out_x     = ex_ff;
   assign out_y     = ey_ff;
   assign out_z     = ez_ff;
   assign out_rem   = n_ff;

endmodule

// ===== hw/rtl/pdb_cell.sv =====
// One cell of the chain: a CORDIC vectoring step and one root digit step.
// Steps past their count pass data through. Depends on pdb_pkg.
module pdb_cell #(
   parameter int unsigned COORD_WIDTH   = 16,
   parameter int unsigned CORDIC_STAGES = 16,
   parameter int unsigned IDX           = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  pdb_pkg::pdb_flags_type         in_flags,
   input  logic signed [COORD_WIDTH+pdb_pkg::XY_GUARD-1:0] in_x,
   input  logic signed [COORD_WIDTH+pdb_pkg::XY_GUARD-1:0] in_y,
   input  logic signed [pdb_pkg::Z_W-1:0] in_z,
   input  logic [pdb_pkg::ROOT_W-1:0]     in_rem,
   input  logic [pdb_pkg::ROOT_W-1:0]     in_res,
   output pdb_pkg::pdb_flags_type         out_flags,
   output logic signed [COORD_WIDTH+pdb_pkg::XY_GUARD-1:0] out_x,
   output logic signed [COORD_WIDTH+pdb_pkg::XY_GUARD-1:0] out_y,
   output logic signed [pdb_pkg::Z_W-1:0] out_z,
   output logic [pdb_pkg::ROOT_W-1:0]     out_rem,
   output logic [pdb_pkg::ROOT_W-1:0]     out_res
);
   import pdb_pkg::*;

   localparam int unsigned XY_W    = COORD_WIDTH + XY_GUARD;
   localparam bit          ROT_EN  = (IDX < CORDIC_STAGES) && (IDX < ATAN_LEN);
   localparam bit          ROOT_EN = (IDX < ROOT_STEPS);
   localparam int unsigned ROOT_SH = ROOT_EN ? 2 * (ROOT_STEPS - 1 - IDX) : 0;
   localparam logic [ROOT_W-1:0] ROOT_BIT = ROOT_W'(1) << ROOT_SH;
   localparam logic signed [Z_W-1:0] ATAN = ATAN_TABLE[IDX % ATAN_LEN];

   pdb_flags_type          flags_ff;
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic [ROOT_W-1:0]      rem_ff, rem_in, res_ff, res_in, trial;

   always_comb begin
      x_in = in_x;
      y_in = in_y;
      z_in = in_z;
      if (ROT_EN) begin
         if (!in_y[XY_W-1]) begin
            x_in = in_x + (in_y >>> IDX);
            y_in = in_y - (in_x >>> IDX);
            z_in = in_z + ATAN;
         end else begin
            x_in = in_x - (in_y >>> IDX);
            y_in = in_y + (in_x >>> IDX);
            z_in = in_z - ATAN;
         end
      end

      trial  = in_res + ROOT_BIT;
      rem_in = in_rem;
      res_in = in_res;
      if (ROOT_EN) begin
         if (in_rem >= trial) begin
            rem_in = in_rem - trial;
            res_in = (in_res >> 1) + ROOT_BIT;
         end else begin
            res_in = in_res >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (adv) begin
         flags_ff <= in_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         rem_ff <= rem_in;
         res_ff <= res_in;
      end
   end

   assign out_flags = flags_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_rem   = rem_ff;
   assign out_res   = res_ff;

endmodule

// ===== hw/rtl/pdb_back.sv =====
// Back end: root rounding and saturation, angle wrap and rounding, and the
// output register. Depends on pdb_pkg.
module pdb_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  pdb_pkg::pdb_flags_type         in_flags,
   input  logic signed [pdb_pkg::Z_W-1:0] in_z,
   input  logic [pdb_pkg::ROOT_W-1:0]     in_rem,
   input  logic [pdb_pkg::ROOT_W-1:0]     in_res,
   output logic                           out_valid,
   output logic [pdb_pkg::DIST_W-1:0]     out_distance,
   output logic [pdb_pkg::BEAR_W-1:0]     out_bearing
);
   import pdb_pkg::*;

   logic                  valid_ff;
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic [BEAR_W-1:0]     bear_ff, bear_in;
   logic [ROOT_W-1:0]     rnd;
   logic signed [Z_W-1:0] zw;
   logic [Z_W:0]          zr;
   logic [BEAR_W:0]       b;

   always_comb begin
      rnd = in_res + ROOT_W'(in_rem > in_res);
      if (in_flags.sat || (rnd > ROOT_W'(DIST_MAX))) begin
         dist_in = DIST_MAX;
      end else begin
         dist_in = rnd[DIST_W-1:0];
      end

      zw = in_z[Z_W-1] ? in_z + DEG360 : in_z;
      zr = ((Z_W + 1)'(unsigned'(zw)) + ROUND_HALF) >> XY_FRAC;
      b  = zr[BEAR_W:0];
      if (b >= BEARING_FULL) begin
         b = b - BEARING_FULL;
      end
      bear_in = in_flags.zero ? '0 : b[BEAR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_flags.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff <= dist_in;
         bear_ff <= bear_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_distance = dist_ff;
   assign out_bearing  = bear_ff;

endmodule

// ===== hw/rtl/point_distance_and_bearing.sv =====
// Top level of the point distance and bearing block.
// Instantiates pdb_front, a chain of pdb_cell and pdb_back. Depends on pdb_pkg.
//
// Usage:
//   req_ channel: one beat carries two points (from, to). Each beat yields
//   exactly one rsp_ beat with the rounded distance in quarter units and the
//   bearing from +y toward +x in 1/64 degree (0 .. 23039).
//   Path: from the accepting edge to rsp_tvalid a beat passes the pdb_front
//   stages, N = max(CORDIC_STAGES, 20) cells and the pdb_back output register.
//   The cell count is set by the 20-digit root and the CORDIC step count.
//   Throughput: one beat per cycle unless stalled, as every cell takes a new pair.
//   Reset clears all valid flags; no beat is in flight afterward.
//   Stall: the whole pipeline holds while rsp_tvalid is high and rsp_tready
//   is low; req_tready drops in the same cycle. An empty output register
//   lets the pipeline advance regardless of rsp_tready.
//   No state is kept between beats.
module point_distance_and_bearing #(
   parameter int unsigned COORD_WIDTH   = 16,
   parameter int unsigned CORDIC_STAGES = 16,
   localparam int unsigned REQ_W = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [REQ_W-1:0]            req_tdata,  // from_x, from_y, to_x, to_y
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [pdb_pkg::RSP_W-1:0]   rsp_tdata   // distance, bearing
);
   import pdb_pkg::*;

   localparam int unsigned XY_W  = COORD_WIDTH + XY_GUARD;
   localparam int unsigned CELLS = (CORDIC_STAGES > ROOT_STEPS) ? CORDIC_STAGES : ROOT_STEPS;
   localparam int unsigned RSP_PAD = RSP_W - DIST_W - BEAR_W;

   logic                          adv;
   logic signed [COORD_WIDTH-1:0] from_x, from_y, to_x, to_y;
   pdb_flags_type                 flags_c [CELLS+1];
   logic signed [XY_W-1:0]        x_c     [CELLS+1];
   logic signed [XY_W-1:0]        y_c     [CELLS+1];
   logic signed [Z_W-1:0]         z_c     [CELLS+1];
   logic [ROOT_W-1:0]             rem_c   [CELLS+1];
   logic [ROOT_W-1:0]             res_c   [CELLS+1];
   logic [DIST_W-1:0]             distance;
   logic [BEAR_W-1:0]             bearing;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   assign from_x = req_tdata[COORD_WIDTH-1:0];
   assign from_y = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign to_x   = req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
   assign to_y   = req_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];

   pdb_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .from_x    (from_x),
      .from_y    (from_y),
      .to_x      (to_x),
      .to_y      (to_y),
      .out_flags (flags_c[0]),
      .out_x     (x_c[0]),
      .out_y     (y_c[0]),
      .out_z     (z_c[0]),
      .out_rem   (rem_c[0])
   );

   assign res_c[0] = '0;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      pdb_cell #(
         .COORD_WIDTH  (COORD_WIDTH),
         .CORDIC_STAGES(CORDIC_STAGES),
         .IDX          (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_flags  (flags_c[i]),
         .in_x      (x_c[i]),
         .in_y      (y_c[i]),
         .in_z      (z_c[i]),
         .in_rem    (rem_c[i]),
         .in_res    (res_c[i]),
         .out_flags (flags_c[i+1]),
         .out_x     (x_c[i+1]),
         .out_y     (y_c[i+1]),
         .out_z     (z_c[i+1]),
         .out_rem   (rem_c[i+1]),
         .out_res   (res_c[i+1])
      );
   end

   pdb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_flags     (flags_c[CELLS]),
      .in_z         (z_c[CELLS]),
      .in_rem       (rem_c[CELLS]),
      .in_res       (res_c[CELLS]),
      .out_valid    (rsp_tvalid),
      .out_distance (distance),
      .out_bearing  (bearing)
   );

   assign rsp_tdata = {{RSP_PAD{1'b0}}, bearing, distance};

endmodule

// ===== hw/rtl/pdb_checker.sv =====
// Port-level checks for point_distance_and_bearing, bound to the top level.
// Depends on pdb_pkg.
module pdb_checker #(
   parameter int unsigned REQ_W = 64
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [REQ_W-1:0]          req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [pdb_pkg::RSP_W-1:0] rsp_tdata
);
   import pdb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_W-1:DIST_W+BEAR_W] == '0) &&
                     ((BEAR_W+1)'(rsp_tdata[DIST_W+BEAR_W-1:DIST_W]) < BEARING_FULL))
      else $error("rsp beat out of range");

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown(req_tdata))
      else $error("req beat carries unknown bits");

   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind point_distance_and_bearing pdb_checker #(
   .REQ_W(REQ_W)
) u_pdb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
